@@ rtl/core/fpalu_pkg.sv @@
// Package for the fixed-point ALU: widths, operation codes, operation kinds
// and the item type passed from the front queue to the back pipeline.
// No dependencies.
`timescale 1ns / 1ps

package fpalu_pkg;

   localparam int DATA_W      = 32;
   localparam int FRAC_BITS   = 8;
   localparam int OP_W        = 4;
   localparam int QUO_W       = DATA_W + FRAC_BITS;
   localparam int DIV_STAGES  = QUO_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int REQ_TDATA_W = 2 * DATA_W;
   localparam int RSP_TDATA_W = ((DATA_W + 2 + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - DATA_W - 2;

   typedef enum logic [OP_W-1:0] {
      OP_ADD     = 4'd0,
      OP_SUB     = 4'd1,
      OP_MUL     = 4'd2,
      OP_DIV     = 4'd3,
      OP_GT      = 4'd4,
      OP_GE      = 4'd5,
      OP_LT      = 4'd6,
      OP_LE      = 4'd7,
      OP_EQ      = 4'd8,
      OP_NE      = 4'd9,
      OP_INC     = 4'd10,
      OP_DEC     = 4'd11,
      OP_MAX     = 4'd12,
      OP_MIN     = 4'd13,
      OP_TOINT   = 4'd14,
      OP_FROMINT = 4'd15
   } op_type;

   typedef enum logic [1:0] {
      KIND_SIMPLE  = 2'd0,
      KIND_MUL     = 2'd1,
      KIND_DIV     = 2'd2,
      KIND_DIVZERO = 2'd3
   } kind_type;

   typedef struct packed {
      op_type              op;
      kind_type            kind;
      logic [DATA_W-1:0]   a;
      logic [DATA_W-1:0]   b;
   } item_type;

endpackage

@@ rtl/core/fpalu_front.sv @@
// Front end of the fixed-point ALU: accepts transactions, classifies them
// and holds them in a short queue for the back pipeline. Uses fpalu_pkg.
`timescale 1ns / 1ps

module fpalu_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [fpalu_pkg::OP_W-1:0]    req_op,
   input  logic [fpalu_pkg::DATA_W-1:0]  req_a,
   input  logic [fpalu_pkg::DATA_W-1:0]  req_b,
   output logic                          head_valid,
   output fpalu_pkg::item_type           head_item,
   input  logic                          head_pop
);
   import fpalu_pkg::*;

   item_type            queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                push;
   logic                pop;
   item_type            new_item;

   always_comb begin
      new_item.op   = op_type'(req_op);
      new_item.a    = req_a;
      new_item.b    = req_b;
      unique case (op_type'(req_op))
         OP_MUL:  new_item.kind = KIND_MUL;
         OP_DIV:  new_item.kind = (req_b == '0) ? KIND_DIVZERO : KIND_DIV;
         default: new_item.kind = KIND_SIMPLE;
      endcase
   end

   assign req_tready = (count_ff != QUEUE_DEPTH[QUEUE_AW:0]);
   assign push       = req_tvalid && req_tready;
   assign head_valid = (count_ff != '0);
   assign pop        = head_pop && head_valid;
   assign head_item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

@@ rtl/core/fpalu_back.sv @@
// Back end of the fixed-point ALU: entry stage with the multiplier, one
// restoring divide step per stage, and the result register. Uses fpalu_pkg.
`timescale 1ns / 1ps

module fpalu_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  fpalu_pkg::item_type           head_item,
   output logic                          head_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [fpalu_pkg::DATA_W-1:0]  rsp_result,
   output logic                          rsp_compare,
   output logic                          rsp_div_zero
);
   import fpalu_pkg::*;

   typedef struct packed {
      kind_type            kind;
      logic [DATA_W-1:0]   res;
      logic                cmp;
      logic                dz;
      logic                neg;
      logic [DATA_W-1:0]   d;
      logic [DATA_W-1:0]   rem;
      logic [QUO_W-1:0]    dvd;
   } stage_type;

   typedef struct packed {
      stage_type           st;
      logic [2*DATA_W-1:0] prod;
   } entry_type;

   // One restoring step: bring down the next dividend bit, subtract if it fits.
   function automatic stage_type div_step(stage_type s);
      logic [DATA_W:0] t;
      logic [DATA_W:0] diff;
      stage_type       r;
      r    = s;
      t    = {s.rem, s.dvd[QUO_W-1]};
      diff = t - {1'b0, s.d};
      if (s.kind == KIND_DIV) begin
         r.rem = diff[DATA_W] ? t[DATA_W-1:0] : diff[DATA_W-1:0];
         r.dvd = {s.dvd[QUO_W-2:0], ~diff[DATA_W]};
      end
      return r;
   endfunction

   logic                     advance;
   entry_type                entry_ff, entry_in;
   logic                     entry_vld_ff;
   stage_type                stg_ff [DIV_STAGES];
   stage_type                stg_in [DIV_STAGES];
   logic [DIV_STAGES-1:0]    vld_ff, vld_in;
   stage_type                first_st;
   stage_type                last_st;
   logic                     rsp_tvalid_ff;
   logic [DATA_W-1:0]        rsp_result_ff, rsp_result_in;
   logic                     rsp_compare_ff;
   logic                     rsp_div_zero_ff;
   logic signed [DATA_W-1:0] sa, sb;
   logic [DATA_W-1:0]        abs_a, abs_b;

   assign advance  = !rsp_tvalid_ff || rsp_tready;
   assign head_pop = advance && head_valid;

   assign sa    = $signed(head_item.a);
   assign sb    = $signed(head_item.b);
   assign abs_a = head_item.a[DATA_W-1] ? DATA_W'(~head_item.a + 1'b1) : head_item.a;
   assign abs_b = head_item.b[DATA_W-1] ? DATA_W'(~head_item.b + 1'b1) : head_item.b;

   always_comb begin
      entry_in.st.kind = head_item.kind;
      entry_in.st.res  = '0;
      entry_in.st.cmp  = 1'b0;
      entry_in.st.dz   = (head_item.kind == KIND_DIVZERO);
      entry_in.st.neg  = head_item.a[DATA_W-1] ^ head_item.b[DATA_W-1];
      entry_in.st.d    = abs_b;
      entry_in.st.rem  = '0;
      entry_in.st.dvd  = {abs_a, {FRAC_BITS{1'b0}}};
      entry_in.prod    = (2*DATA_W)'(sa) * (2*DATA_W)'(sb);
      unique case (head_item.op)
         OP_ADD:     entry_in.st.res = head_item.a + head_item.b;
         OP_SUB:     entry_in.st.res = head_item.a - head_item.b;
         OP_GT:      entry_in.st.cmp = (sa > sb);
         OP_GE:      entry_in.st.cmp = (sa >= sb);
         OP_LT:      entry_in.st.cmp = (sa < sb);
         OP_LE:      entry_in.st.cmp = (sa <= sb);
         OP_EQ:      entry_in.st.cmp = (sa == sb);
         OP_NE:      entry_in.st.cmp = (sa != sb);
         OP_INC:     entry_in.st.res = head_item.a + 1'b1;
         OP_DEC:     entry_in.st.res = head_item.a - 1'b1;
         OP_MAX:     entry_in.st.res = (sa >= sb) ? head_item.a : head_item.b;
         OP_MIN:     entry_in.st.res = (sa <= sb) ? head_item.a : head_item.b;
         OP_TOINT:   entry_in.st.res = DATA_W'(sa >>> FRAC_BITS);
         OP_FROMINT: entry_in.st.res = head_item.a << FRAC_BITS;
         default:    entry_in.st.res = '0;
      endcase
   end

   // The product is registered at entry and scaled on its way into stage 0.
   always_comb begin
      first_st = entry_ff.st;
      if (entry_ff.st.kind == KIND_MUL) begin
         first_st.res = entry_ff.prod[FRAC_BITS +: DATA_W];
      end
      stg_in[0] = div_step(first_st);
      for (int k = 1; k < DIV_STAGES; k++) begin
         stg_in[k] = div_step(stg_ff[k-1]);
      end
   end

   assign vld_in  = {vld_ff[DIV_STAGES-2:0], entry_vld_ff};
   assign last_st = stg_ff[DIV_STAGES-1];

   always_comb begin
      rsp_result_in = last_st.res;
      if (last_st.kind == KIND_DIV) begin
         rsp_result_in = last_st.neg ? DATA_W'(~last_st.dvd[DATA_W-1:0] + 1'b1)
                                     : last_st.dvd[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff  <= 1'b0;
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         entry_vld_ff  <= head_valid;
         vld_ff        <= vld_in;
         rsp_tvalid_ff <= vld_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff        <= entry_in;
         stg_ff          <= stg_in;
         rsp_result_ff   <= rsp_result_in;
         rsp_compare_ff  <= last_st.cmp;
         rsp_div_zero_ff <= last_st.dz;
      end
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_result   = rsp_result_ff;
   assign rsp_compare  = rsp_compare_ff;
   assign rsp_div_zero = rsp_div_zero_ff;

   a_dz_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_div_zero_ff |-> rsp_result_ff == '0)
      else $error("divide by zero with non-zero result");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> !(rsp_compare_ff && rsp_div_zero_ff))
      else $error("compare and divide-by-zero flags both set");

   a_cmp_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_compare_ff |-> rsp_result_ff == '0)
      else $error("comparison with non-zero result");

   a_no_pop_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !rsp_tready |-> !head_pop)
      else $error("queue popped while pipeline stalled");

endmodule

@@ rtl/core/fixed_point_alu_top.sv @@
// Usage: signed 32-bit fixed-point ALU with 8 fraction bits.
// Request channel (req_): tuser carries the operation code, tdata the two
// raw operands. Response channel (rsp_): tdata carries the raw result and
// the comparison and divide-by-zero flags.
// A transaction is moved when tvalid and tready are both high.
// Every operation takes the same path from request to response (queue, entry
// stage with the multiplier, 40 divide stages of one quotient bit each, result
// register), so responses leave in request order.
// Throughput is one transaction per cycle while rsp_tready does not hold the
// pipeline; the 40-stage divide pipeline sets the latency, not the rate.
// The four-entry queue parts the request side from the pipeline: req_tready
// drops only when the queue is full.
// When the receiver holds rsp_tready low, the whole pipeline freezes and the
// queue fills; nothing is lost or repeated.
// Synchronous reset empties the queue and clears all valid bits.
// Depends on fpalu_pkg, fpalu_front and fpalu_back.
`timescale 1ns / 1ps

module fixed_point_alu_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] operand_a, [63:32] operand_b
   input  logic [fpalu_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [3:0] operation
   input  logic [fpalu_pkg::OP_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] result_value, [32] compare_true, [33] divide_by_zero, rest zero
   output logic [fpalu_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import fpalu_pkg::*;

   logic              head_valid;
   item_type          head_item;
   logic              head_pop;
   logic [DATA_W-1:0] result;
   logic              compare;
   logic              div_zero;

   fpalu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_a      (req_tdata[DATA_W-1:0]),
      .req_b      (req_tdata[2*DATA_W-1:DATA_W]),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop)
   );

   fpalu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_item    (head_item),
      .head_pop     (head_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_result   (result),
      .rsp_compare  (compare),
      .rsp_div_zero (div_zero)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, div_zero, compare, result};

endmodule

@@ tb/fixed_point_alu_top_test.sv @@
// Self-checking testbench for the fixed-point ALU: directed corner operands,
// then random bursts, with a scoreboard that predicts every response.
// Depends on fpalu_pkg and fixed_point_alu_top.
`timescale 1ns / 1ps

module fixed_point_alu_top_test;
   import fpalu_pkg::*;

   typedef struct packed {
      logic [31:0] value;
      logic        cmp;
      logic        dz;
   } alu_result_type;

   int unsigned error_count = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   class alu_scoreboard;
      alu_result_type pending[$];
      int unsigned ops_seen[16];
      int unsigned checked = 0;

      function alu_result_type compute(op_type op, logic signed [31:0] a,
                                       logic signed [31:0] b);
         alu_result_type r;
         logic signed [63:0] prod;
         logic signed [63:0] num;
         logic signed [63:0] quo;
         r = '0;
         case (op)
            OP_ADD: r.value = a + b;
            OP_SUB: r.value = a - b;
            OP_MUL: begin
               prod = 64'(a) * 64'(b);
               r.value = 32'(prod >>> FRAC_BITS);
            end
            OP_DIV: begin
               if (b == 0) begin
                  r.dz = 1'b1;
               end else begin
                  num = 64'(a) <<< FRAC_BITS;
                  quo = num / 64'(b);
                  r.value = quo[31:0];
               end
            end
            OP_GT: r.cmp = a > b;
            OP_GE: r.cmp = a >= b;
            OP_LT: r.cmp = a < b;
            OP_LE: r.cmp = a <= b;
            OP_EQ: r.cmp = a == b;
            OP_NE: r.cmp = a != b;
            OP_INC: r.value = a + 32'sd1;
            OP_DEC: r.value = a - 32'sd1;
            OP_MAX: r.value = (a >= b) ? a : b;
            OP_MIN: r.value = (a <= b) ? a : b;
            OP_TOINT: r.value = a >>> FRAC_BITS;
            default: r.value = a << FRAC_BITS;
         endcase
         return r;
      endfunction

      function void note_request(op_type op, logic [31:0] a, logic [31:0] b);
         pending.push_back(compute(op, a, b));
         ops_seen[op]++;
      endfunction

      task check_response(logic [RSP_TDATA_W-1:0] data);
         alu_result_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected response", data[31:0], 32'h0);
         end else begin
            want = pending.pop_front();
            checked++;
            if (data[31:0] !== want.value) report_mismatch("result_value", data[31:0], want.value);
            if (data[32] !== want.cmp) report_mismatch("compare_true", data[32], want.cmp);
            if (data[33] !== want.dz) report_mismatch("divide_by_zero", data[33], want.dz);
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   alu_scoreboard board = new();
   bit stall_enable = 1'b1;

   always #5 clock = ~clock;

   fixed_point_alu_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // Note both sides of each transaction on the same edge the DUT sees it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_request(op_type'(req_tuser), req_tdata[31:0], req_tdata[63:32]);
         if (rsp_tvalid && rsp_tready)
            board.check_response(rsp_tdata);
      end
   end

   // Receiver stalls in stretches: open phases mix at random with sparse
   // or heavy back-pressure.
   initial begin
      int mode;
      int span;
      @(posedge clock);
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(5, 60);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= !stall_enable || ($urandom_range(0, 3) != 0);
               default: rsp_tready <= !stall_enable || ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic send_item(input op_type op, input logic [31:0] a, input logic [31:0] b);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000 + $urandom_range(0, 2);
         1: return 32'h7FFF_FFFF - $urandom_range(0, 2);
         2: return 32'($signed($urandom_range(0, 1024)) - 512);
         3: return 32'($urandom_range(0, 3)) << FRAC_BITS;
         4: return '0;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] corners[6];
      int burst;
      int sent;
      corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h100, 32'hFFFF_FF00};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every operation on corner pairs, including divide by zero and max/min ties.
      for (int op = 0; op < 16; op++)
         send_item(op_type'(op), corners[op % 6], corners[(op + 3) % 6]);
      send_item(OP_DIV, 32'h7FFF_FFFF, 32'h0);
      send_item(OP_MAX, 32'h1234, 32'h1234);
      send_item(OP_MIN, 32'h8000_0000, 32'h8000_0000);
      send_item(OP_TOINT, 32'hFFFF_FF01, 32'h0);
      send_item(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000);

      // Hold off until the pipeline has drained completely.
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);

      sent = 0;
      while (sent < 2000) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            send_item(op_type'($urandom_range(0, 15)), pick_operand(), pick_operand());
            sent++;
         end
         if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
         if (sent > 1500) stall_enable = 1'b0;
      end
      req_tvalid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("covered %0d checked responses over all 16 operations, with random gaps",
               board.checked);
      $display("and receiver stalls; divide count %0d, multiply count %0d",
               board.ops_seen[OP_DIV], board.ops_seen[OP_MUL]);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
